### hw/rtl/stp_pkg.sv
// Shared constants and types for the scatter point to pixel mapper.
`default_nettype none

package stp_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int ROW_OFFSET   = 32;

  localparam int COORD_W = 24;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;

  // The quotient is below SCREEN_WIDTH, so this many bits hold it.
  localparam int QUO_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  // The scaled offset is below divisor * 2^QUO_W.
  localparam int REM_W = COORD_W + QUO_W;
  localparam int ROW_SUM_W = $clog2(ROW_OFFSET + SCREEN_WIDTH + 1) + ROW_W;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             in_win;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
  } cell_t;

endpackage

`default_nettype wire

### hw/rtl/stp_div_cell.sv
// One restoring-division cell: resolves one quotient bit for both axes.
`default_nettype none

module stp_div_cell
  import stp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [REM_W-1:0] dom_hi,
  input  wire logic [REM_W-1:0] rng_hi,
  input  wire cell_t            cell_in,
  output cell_t                 cell_out
);

  logic             ge_x;
  logic             ge_y;
  logic [REM_W-1:0] diff_x;
  logic [REM_W-1:0] diff_y;
  cell_t            cell_next;

  always_comb begin
    ge_x   = (cell_in.rem_x >= dom_hi);
    ge_y   = (cell_in.rem_y >= rng_hi);
    diff_x = ge_x ? (cell_in.rem_x - dom_hi) : cell_in.rem_x;
    diff_y = ge_y ? (cell_in.rem_y - rng_hi) : cell_in.rem_y;

    cell_next        = cell_in;
    // After a subtract the remainder is below the shifted divisor: no bit drops.
    cell_next.rem_x  = diff_x << 1;
    cell_next.rem_y  = diff_y << 1;
    cell_next.quo_x  = QUO_W'({cell_in.quo_x, ge_x});
    cell_next.quo_y  = QUO_W'({cell_in.quo_y, ge_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scatter_point_to_pixel.sv
// Top level of the scatter point to pixel mapper.
`default_nettype none

// Maps a stream of signed fixed-point points (x, y) to screen pixels of a
// scatter plot. A point strictly inside the configured window yields
// column = (x - x_min) * SCREEN_WIDTH / (x_max - x_min) and
// row = 32 + SCREEN_WIDTH - (y - y_min) * SCREEN_WIDTH / (y_max - y_min),
// both truncated; any other point comes out with in_bounds low and zero
// coordinates. One word enters per clock and one leaves per clock while
// the output is not stalled. A word accepted at the input passes, in order,
// an entry register that tests the window and scales the offsets (loaded at
// the accepting edge), a row of QUO_W division cells that each settle one
// quotient bit for both axes, and an output register.
// A stalled output holds the whole row in place. Write the window
// registers only while no word is in flight; a word may follow a write in
// the next cycle.
module scatter_point_to_pixel
  import stp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  // Window register write port.
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [COORD_W-1:0]   cfg_wdata,

  // Point input.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [47:0]          s_tdata,   // point_x[23:0], point_y[47:24]
  input  wire logic                 s_tlast,   // set_end

  // Pixel output.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,   // pixel_column[6:0], pixel_row[14:7], zero
  output logic                      m_tuser,   // in_bounds
  output logic                      m_tlast    // set_end_out
);

  // Window registers.
  logic signed [COORD_W-1:0] x_min;
  logic signed [COORD_W-1:0] x_max;
  logic signed [COORD_W-1:0] y_min;
  logic signed [COORD_W-1:0] y_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= COORD_W'(0);
      x_max <= COORD_W'(1000);
      y_min <= COORD_W'(0);
      y_max <= COORD_W'(1000);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_X_MIN: x_min <= cfg_wdata;
        REG_X_MAX: x_max <= cfg_wdata;
        REG_Y_MIN: y_min <= cfg_wdata;
        REG_Y_MAX: y_max <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Divisors, aligned to the top quotient bit. Registered so the cells see
  // only a compare and subtract; they are only meaningful for a valid window.
  logic signed [COORD_W:0] dom_wide;
  logic signed [COORD_W:0] rng_wide;
  logic [REM_W-1:0]        dom_hi;
  logic [REM_W-1:0]        rng_hi;

  assign dom_wide = {x_max[COORD_W-1], x_max} - {x_min[COORD_W-1], x_min};
  assign rng_wide = {y_max[COORD_W-1], y_max} - {y_min[COORD_W-1], y_min};

  always_ff @(posedge clk) begin
    dom_hi <= REM_W'(dom_wide[COORD_W-1:0]) << (QUO_W - 1);
    rng_hi <= REM_W'(rng_wide[COORD_W-1:0]) << (QUO_W - 1);
  end

  // Global advance: the row moves whenever the output slot is free or taken.
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Entry stage: window test and scaling by the screen width.
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W:0]   dx_wide;
  logic signed [COORD_W:0]   dy_wide;
  logic                      in_win;
  cell_t                     entry_next;

  assign px = s_tdata[COORD_W-1:0];
  assign py = s_tdata[2*COORD_W-1:COORD_W];

  assign dx_wide = {px[COORD_W-1], px} - {x_min[COORD_W-1], x_min};
  assign dy_wide = {py[COORD_W-1], py} - {y_min[COORD_W-1], y_min};

  always_comb begin
    in_win = (px > x_min) && (px < x_max) && (py > y_min) && (py < y_max);
    entry_next        = '0;
    entry_next.valid  = s_tvalid;
    entry_next.last   = s_tlast;
    entry_next.in_win = in_win;
    // Drop the offsets of an outside point so the quotient comes out zero.
    if (in_win) begin
      entry_next.rem_x = REM_W'(dx_wide[COORD_W-1:0]) * REM_W'(SCREEN_WIDTH);
      entry_next.rem_y = REM_W'(dy_wide[COORD_W-1:0]) * REM_W'(SCREEN_WIDTH);
    end
  end

  cell_t stage [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (advance) begin
      stage[0] <= entry_next;
    end
  end

  // Division row: cell k settles quotient bit QUO_W-1-k.
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    stp_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .dom_hi   (dom_hi),
      .rng_hi   (rng_hi),
      .cell_in  (stage[k]),
      .cell_out (stage[k+1])
    );
  end

  // Output stage: form column and row, zero both for an outside point.
  cell_t                  tail;
  logic [QUO_W+COL_W-1:0] col_wide;
  logic [ROW_SUM_W-1:0]   row_sum;
  logic [COL_W-1:0]       col_next;
  logic [ROW_W-1:0]       row_next;

  assign tail = stage[QUO_W];

  always_comb begin
    col_wide = (QUO_W+COL_W)'(tail.quo_x);
    row_sum  = ROW_SUM_W'(ROW_OFFSET + SCREEN_WIDTH) - ROW_SUM_W'(tail.quo_y);
    col_next = tail.in_win ? col_wide[COL_W-1:0] : '0;
    row_next = tail.in_win ? row_sum[ROW_W-1:0]  : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= tail.valid;
      m_tdata  <= {1'b0, row_next, col_next};
      m_tuser  <= tail.in_win;
      m_tlast  <= tail.last;
    end
  end

  // An inside point never yields a quotient at or beyond the screen width.
  a_quo_range : assert property (@(posedge clk) disable iff (rst)
    tail.valid && tail.in_win |->
      (tail.quo_x < SCREEN_WIDTH) && (tail.quo_y < SCREEN_WIDTH))
    else $error("quotient beyond screen width");

  // An outside point reaches the end of the row with an empty quotient on
  // every axis whose window is not empty; a zero divisor sets every bit.
  a_outside_zero : assert property (@(posedge clk) disable iff (rst)
    tail.valid && !tail.in_win |->
      ((tail.quo_x == '0) || (dom_hi == '0)) &&
      ((tail.quo_y == '0) || (rng_hi == '0)))
    else $error("outside point carries a quotient");

  // An outside word leaves with zero coordinates.
  a_out_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata == '0))
    else $error("outside word has nonzero coordinates");

  // A word accepted at the entry is loaded into the entry register by the advance that takes it.
  a_entry_flow : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stage[0].valid)
    else $error("accepted word lost at entry stage");

endmodule

`default_nettype wire
